// ----- rtl/core/cpr_pkg.sv -----
// Shared types, constants and helpers for the clock page replacement unit.
package cpr_pkg;

  localparam int FRAMES  = 64;
  localparam int AW      = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int IW      = ((AW > 6) ? AW : 6) + 1;
  localparam int SCAN_N  = 2 * FRAMES;
  localparam int CW      = $clog2(SCAN_N);
  localparam int QDEPTH  = 2;
  localparam int QPW     = $clog2(QDEPTH);
  localparam int QCW     = $clog2(QDEPTH + 1);

  typedef logic [AW-1:0] frame_idx_t;

  typedef enum logic [1:0] {
    MODE_ALLOC  = 2'd0,
    MODE_ACCESS = 2'd1,
    MODE_UNPIN  = 2'd2,
    MODE_WRITE  = 2'd3
  } cpr_mode_t;

  typedef struct packed {
    cpr_mode_t  kind;
    logic [5:0] frame;
    frame_idx_t idx;
    logic       in_range;
    logic       pin;
    logic       used;
  } cpr_op_t;

  function automatic frame_idx_t next_frame(input frame_idx_t f);
    next_frame = (f == AW'(FRAMES - 1)) ? '0 : f + AW'(1);
  endfunction

endpackage

// ----- rtl/core/cpr_front.sv -----
// Front end: accepts request items and decodes them into queue entries.
module cpr_front
  import cpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [5:0] in_frame,
  input  logic       in_pin,
  input  logic       in_mark_used,
  input  logic       q_full,
  output logic       q_push,
  output cpr_op_t    q_op
);

  logic [IW-1:0] frame_ext;

  assign frame_ext = IW'(in_frame);
  assign in_ready  = !q_full;
  assign q_push    = in_valid && in_ready;

  always_comb begin
    q_op.frame    = in_frame;
    q_op.idx      = frame_ext[AW-1:0];
    q_op.pin      = in_pin;
    q_op.used     = in_mark_used;
    q_op.in_range = 1'b0;
    unique case (cpr_mode_t'(in_mode))
      MODE_ALLOC: begin
        q_op.kind = MODE_ALLOC;
      end
      MODE_ACCESS: begin
        q_op.kind     = MODE_ACCESS;
        q_op.in_range = frame_ext < IW'(FRAMES);
      end
      MODE_UNPIN: begin
        q_op.kind     = MODE_UNPIN;
        q_op.in_range = frame_ext < IW'(FRAMES);
      end
      default: begin
        q_op.kind     = MODE_WRITE;
        q_op.in_range = frame_ext < IW'(FRAMES);
      end
    endcase
  end

  // Nothing is pushed while the queue is full.
  assert property (@(posedge clk) disable iff (!rst_n) q_full |-> !q_push)
    else $error("front pushed into a full queue");

endmodule

// ----- rtl/core/cpr_queue.sv -----
// Short request queue between the front end and the replacement engine.
module cpr_queue
  import cpr_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    push,
  input  cpr_op_t push_op,
  output logic    full,
  input  logic    pop,
  output logic    head_valid,
  output cpr_op_t head_op
);

  cpr_op_t            mem [QDEPTH];
  logic [QPW-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QCW-1:0]     count_r;

  assign full       = (count_r == QCW'(QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_op    = mem[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr_r] <= push_op;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == QPW'(QDEPTH - 1)) ? '0 : wr_ptr_r + QPW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == QPW'(QDEPTH - 1)) ? '0 : rd_ptr_r + QPW'(1);
      end
      if (push && !pop) begin
        count_r <= count_r + QCW'(1);
      end else if (pop && !push) begin
        count_r <= count_r - QCW'(1);
      end
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n) pop |-> head_valid)
    else $error("pop from empty queue");

endmodule

// ----- rtl/core/cpr_engine.sv -----
// Replacement engine: frame bit state, clock arm scan and result register.
module cpr_engine
  import cpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       head_valid,
  input  cpr_op_t    head_op,
  output logic       pop,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_result_frame,
  output logic       out_writeback,
  output logic       out_no_victim
);

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t            state_r, state_nxt;
  logic [FRAMES-1:0] ref_r, ref_nxt;
  logic [FRAMES-1:0] pin_r, pin_nxt;
  logic [FRAMES-1:0] dirty_r, dirty_nxt;
  frame_idx_t        arm_r, arm_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic              req_pin_r, req_pin_nxt;
  logic              req_used_r, req_used_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [5:0]        out_frame_r, out_frame_nxt;
  logic              out_wb_r, out_wb_nxt;
  logic              out_none_r, out_none_nxt;
  logic              out_free;

  assign out_free         = !out_valid_r || out_ready;
  assign pop              = (state_r == ST_IDLE) && head_valid && out_free;
  assign out_valid        = out_valid_r;
  assign out_result_frame = out_frame_r;
  assign out_writeback    = out_wb_r;
  assign out_no_victim    = out_none_r;

  always_comb begin
    state_nxt     = state_r;
    ref_nxt       = ref_r;
    pin_nxt       = pin_r;
    dirty_nxt     = dirty_r;
    arm_nxt       = arm_r;
    cnt_nxt       = cnt_r;
    req_pin_nxt   = req_pin_r;
    req_used_nxt  = req_used_r;
    out_valid_nxt = out_valid_r && !out_ready;
    out_frame_nxt = out_frame_r;
    out_wb_nxt    = out_wb_r;
    out_none_nxt  = out_none_r;
    unique case (state_r)
      ST_IDLE: begin
        if (pop) begin
          case (head_op.kind)
            MODE_ALLOC: begin
              arm_nxt      = next_frame(arm_r);
              cnt_nxt      = '0;
              req_pin_nxt  = head_op.pin;
              req_used_nxt = head_op.used;
              state_nxt    = ST_SCAN;
            end
            MODE_ACCESS: begin
              if (head_op.in_range) begin
                ref_nxt[head_op.idx] = 1'b1;
                if (head_op.pin) begin
                  pin_nxt[head_op.idx] = 1'b1;
                end
              end
            end
            MODE_UNPIN: begin
              if (head_op.in_range) begin
                pin_nxt[head_op.idx] = 1'b0;
              end
            end
            default: begin
              if (head_op.in_range) begin
                dirty_nxt[head_op.idx] = 1'b1;
                ref_nxt[head_op.idx]   = 1'b1;
              end
            end
          endcase
          if (head_op.kind != MODE_ALLOC) begin
            out_valid_nxt = 1'b1;
            out_frame_nxt = head_op.frame;
            out_wb_nxt    = 1'b0;
            out_none_nxt  = 1'b0;
          end
        end
      end
      ST_SCAN: begin
        if (!pin_r[arm_r] && !ref_r[arm_r]) begin
          // victim: report, clear dirty, load pin and reference from request
          out_valid_nxt    = 1'b1;
          out_frame_nxt    = 6'(arm_r);
          out_wb_nxt       = dirty_r[arm_r];
          out_none_nxt     = 1'b0;
          dirty_nxt[arm_r] = 1'b0;
          pin_nxt[arm_r]   = req_pin_r;
          ref_nxt[arm_r]   = req_used_r;
          state_nxt        = ST_IDLE;
        end else begin
          if (!pin_r[arm_r]) begin
            ref_nxt[arm_r] = 1'b0;  // second chance
          end
          arm_nxt = next_frame(arm_r);
          cnt_nxt = cnt_r + CW'(1);
          if (cnt_r == CW'(SCAN_N - 1)) begin
            // two sweeps with every frame pinned; arm is back at scan start
            out_valid_nxt = 1'b1;
            out_frame_nxt = '0;
            out_wb_nxt    = 1'b0;
            out_none_nxt  = 1'b1;
            state_nxt     = ST_IDLE;
          end
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      ref_r       <= '0;
      pin_r       <= '0;
      dirty_r     <= '0;
      arm_r       <= '0;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ref_r       <= ref_nxt;
      pin_r       <= pin_nxt;
      dirty_r     <= dirty_nxt;
      arm_r       <= arm_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    req_pin_r   <= req_pin_nxt;
    req_used_r  <= req_used_nxt;
    out_frame_r <= out_frame_nxt;
    out_wb_r    <= out_wb_nxt;
    out_none_r  <= out_none_nxt;
  end

  // The result register is empty for the whole scan.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> !out_valid_r)
    else $error("result pending during scan");

  assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_none_r) |-> (!out_wb_r && (out_frame_r == 6'd0)))
    else $error("no-victim result carries a frame or write-back");

  assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, arm_r} < (AW + 1)'(FRAMES))
    else $error("clock arm out of range");

  // A victim leaves its frame loaded from the request.
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && !pin_r[arm_r] && !ref_r[arm_r])
      |=> (pin_r[$past(arm_r)] == $past(req_pin_r)) && !dirty_r[$past(arm_r)])
    else $error("victim frame bits not updated");

endmodule

// ----- rtl/core/clock_page_replacement_unit.sv -----
// Top level of the clock (second-chance) page replacement unit.
//
// Usage:
//   Request items enter on in_* (valid/ready): in_mode picks allocate (0),
//   access (1), unpin (2) or write (3); in_frame names the frame for the
//   last three; in_pin and in_mark_used load the allocated frame's bits, and in_pin on an access also pins the frame.
//   Every item gives exactly one result item on out_* (valid/ready):
//   the victim (or echoed) frame, a write-back flag and a no-victim flag.
//   Access, unpin and write items are registered in the queue and then in
//   the result register. An allocate goes from the queue through the scan
//   state, where the arm examines 1 to 2*FRAMES = 128 frames, to the result
//   register. A two-entry queue decouples the input side, so up to two
//   items are taken while the engine scans.
//   Throughput: with out_ready high the engine takes one access, unpin or
//   write item per cycle; an allocate holds it until its scan ends.
//   Reset (rst_n low, synchronous) clears all pinned, referenced and dirty
//   bits and parks the arm on frame 0. If the receiver holds out_ready low
//   the result register holds its item, the engine waits, and in_ready
//   drops once the queue fills.
module clock_page_replacement_unit
  import cpr_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [1:0] in_mode,
  input  logic [5:0] in_frame,
  input  logic       in_pin,
  input  logic       in_mark_used,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [5:0] out_result_frame,
  output logic       out_writeback,
  output logic       out_no_victim
);

  // front -> queue
  logic    q_full, q_push;
  cpr_op_t q_push_op;
  // queue -> engine
  logic    q_pop, q_head_valid;
  cpr_op_t q_head_op;

  cpr_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_mode      (in_mode),
    .in_frame     (in_frame),
    .in_pin       (in_pin),
    .in_mark_used (in_mark_used),
    .q_full       (q_full),
    .q_push       (q_push),
    .q_op         (q_push_op)
  );

  cpr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_op    (q_push_op),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_op    (q_head_op)
  );

  // Engine owns the frame bits, the arm and the result register.
  cpr_engine u_engine (
    .clk              (clk),
    .rst_n            (rst_n),
    .head_valid       (q_head_valid),
    .head_op          (q_head_op),
    .pop              (q_pop),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_frame (out_result_frame),
    .out_writeback    (out_writeback),
    .out_no_victim    (out_no_victim)
  );

endmodule

// ----- tb/testbench.sv -----
// Testbench for the clock page replacement unit: self-checking, random traffic with stalls.
`timescale 1ns / 100ps

module testbench;
  import cpr_pkg::*;

  localparam int RANDOM_ITEMS  = 320;
  localparam int STALL_LIMIT   = 2000;           // cycles without any handshake
  localparam int LONG_HOLD     = 300;            // receiver hold-off, in cycles
  localparam int DRAIN_CYCLES  = 2 * FRAMES + 16;
  localparam int MAX_GAP       = 30;

  typedef struct packed {
    logic [5:0] frame;
    logic       writeback;
    logic       no_victim;
  } outcome_t;

  // Tracks frame state and the results still owed by the block.
  class clock_scoreboard;
    bit       referenced [FRAMES];
    bit       pinned     [FRAMES];
    bit       dirty      [FRAMES];
    int       arm;
    outcome_t owed [$];
    int       mismatches;
    int       checked;
    int       allocations;
    int       writebacks;
    int       no_victims;

    function new();
      foreach (referenced[i]) begin
        referenced[i] = 1'b0;
        pinned[i]     = 1'b0;
        dirty[i]      = 1'b0;
      end
      arm = 0;
    endfunction

    function int advance(int f);
      return (f + 1 >= FRAMES) ? 0 : f + 1;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // Update the frame state for one accepted request and queue its result.
    function void note_request(cpr_mode_t mode, logic [5:0] frame, logic pin, logic used);
      outcome_t want;
      bit       found;
      int       n;
      want.frame     = frame;
      want.writeback = 1'b0;
      want.no_victim = 1'b0;
      if (mode == MODE_ALLOC) begin
        allocations++;
        arm   = advance(arm);
        found = 1'b0;
        n     = 0;
        // second chance: skip pinned, clear referenced, stop on the first frame neither pinned nor referenced
        while (!found && n < 2 * FRAMES) begin
          if (!pinned[arm] && !referenced[arm]) begin
            found = 1'b1;
          end else begin
            if (!pinned[arm]) referenced[arm] = 1'b0;
            arm = advance(arm);
            n++;
          end
        end
        if (found) begin
          want.frame      = 6'(arm);
          want.writeback  = dirty[arm];
          dirty[arm]      = 1'b0;
          pinned[arm]     = pin;
          referenced[arm] = used;
          if (want.writeback) writebacks++;
        end else begin
          want.frame     = '0;
          want.no_victim = 1'b1;
          no_victims++;
        end
      end else if (int'(frame) < FRAMES) begin
        case (mode)
          MODE_ACCESS: begin
            referenced[frame] = 1'b1;
            if (pin) pinned[frame] = 1'b1;
          end
          MODE_UNPIN: begin
            pinned[frame] = 1'b0;
          end
          default: begin
            dirty[frame]      = 1'b1;
            referenced[frame] = 1'b1;
          end
        endcase
      end
      owed.push_back(want);
    endfunction

    task report_mismatch(string what, int unsigned want, int unsigned got);
      mismatches++;
      if (mismatches <= 40)
        $display("%0t: result %0d %s: expected %0d, got %0d", $time, checked, what, want, got);
    endtask

    task check_result(logic [5:0] frame, logic writeback, logic no_victim);
      outcome_t want;
      if (owed.size() == 0) begin
        report_mismatch("arrived with nothing outstanding", 0, frame);
      end else begin
        want = owed.pop_front();
        if (frame !== want.frame) report_mismatch("result_frame", want.frame, frame);
        if (writeback !== want.writeback) report_mismatch("writeback", want.writeback, writeback);
        if (no_victim !== want.no_victim) report_mismatch("no_victim", want.no_victim, no_victim);
      end
      checked++;
    endtask
  endclass

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_ready;
  logic [1:0] in_mode      = '0;
  logic [5:0] in_frame     = '0;
  logic       in_pin       = 1'b0;
  logic       in_mark_used = 1'b0;
  logic       out_valid;
  logic       out_ready    = 1'b0;
  logic [5:0] out_result_frame;
  logic       out_writeback;
  logic       out_no_victim;

  clock_scoreboard sb = new();

  int send_idle_pct = 12;
  int recv_idle_pct = 72;
  bit hold_asked    = 1'b0;
  bit hold_done     = 1'b0;
  int quiet_cycles  = 0;

  clock_page_replacement_unit u_top (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_mode          (in_mode),
    .in_frame         (in_frame),
    .in_pin           (in_pin),
    .in_mark_used     (in_mark_used),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_frame (out_result_frame),
    .out_writeback    (out_writeback),
    .out_no_victim    (out_no_victim)
  );

  always #5 clk = ~clk;

  // Handshakes are sampled at the edge, before this edge's updates land.
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready)
        sb.note_request(cpr_mode_t'(in_mode), in_frame, in_pin, in_mark_used);
      if (out_valid && out_ready)
        sb.check_result(out_result_frame, out_writeback, out_no_victim);
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (hold_asked && !hold_done) begin
        out_ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_done = 1'b1;
      end else begin
        out_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Watchdog: ends the run if the handshakes stop moving.
  initial begin : watchdog
    forever begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready))
        quiet_cycles = 0;
      else
        quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, sb.pending());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // Offer one request item; returns once it has been accepted.
  task automatic send_request(cpr_mode_t mode, logic [5:0] frame, logic pin, logic used);
    int gap;
    gap = 0;
    while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_frame     <= frame;
    in_pin       <= pin;
    in_mark_used <= used;
    do @(posedge clk); while (!in_ready);
  endtask

  task automatic run_directed();
    send_request(MODE_ALLOC,  6'd0,  1'b0, 1'b0);  // empty pool: arm steps to frame 1
    send_request(MODE_ACCESS, 6'd0,  1'b1, 1'b0);
    send_request(MODE_ACCESS, 6'd63, 1'b0, 1'b1);
    send_request(MODE_WRITE,  6'd63, 1'b0, 1'b0);
    send_request(MODE_WRITE,  6'd2,  1'b1, 1'b1);
    send_request(MODE_ALLOC,  6'd63, 1'b1, 1'b1);  // passes referenced frame 2
    send_request(MODE_ACCESS, 6'd3,  1'b0, 1'b0);  // pin 0 keeps the pin
    send_request(MODE_ALLOC,  6'd0,  1'b0, 1'b0);
    send_request(MODE_UNPIN,  6'd3,  1'b0, 1'b0);
    send_request(MODE_UNPIN,  6'd0,  1'b1, 1'b1);
    send_request(MODE_ACCESS, 6'd21, 1'b1, 1'b0);
    send_request(MODE_WRITE,  6'd42, 1'b0, 1'b1);
    send_request(MODE_ALLOC,  6'd42, 1'b0, 1'b1);
    send_request(MODE_UNPIN,  6'd21, 1'b0, 1'b0);
    send_request(MODE_WRITE,  6'd0,  1'b0, 1'b0);
    send_request(MODE_ACCESS, 6'd62, 1'b1, 1'b1);
    send_request(MODE_UNPIN,  6'd62, 1'b0, 1'b0);
    send_request(MODE_ALLOC,  6'd21, 1'b1, 1'b0);
    send_request(MODE_ALLOC,  6'd0,  1'b0, 1'b0);
  endtask

  // Pin the whole pool through allocations, see the no-victim case, then release it.
  task automatic pin_every_frame();
    int open_frame;
    repeat (FRAMES + 2)
      send_request(MODE_ALLOC, 6'($urandom_range(63)), 1'b1, 1'($urandom_range(1)));
    open_frame = $urandom_range(FRAMES - 1);
    send_request(MODE_UNPIN, 6'(open_frame), 1'b0, 1'b0);
    send_request(MODE_ALLOC, 6'($urandom_range(63)), 1'b1, 1'($urandom_range(1)));
    send_request(MODE_ALLOC, 6'($urandom_range(63)), 1'b0, 1'b0);  // all pinned again
    for (int f = 0; f < FRAMES; f++)
      send_request(MODE_UNPIN, 6'(f), 1'($urandom_range(1)), 1'($urandom_range(1)));
  endtask

  task automatic run_random();
    int unsigned pick;
    cpr_mode_t   mode;
    logic        pin;
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == RANDOM_ITEMS / 3) begin
        send_idle_pct = 72;
        recv_idle_pct = 12;
      end
      if (i == RANDOM_ITEMS / 2) pin_every_frame();
      if (i == 2 * RANDOM_ITEMS / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_asked    = 1'b1;   // long back-pressure while requests keep coming
      end
      pick = $urandom_range(99);
      if (pick < 35)      mode = MODE_ALLOC;
      else if (pick < 60) mode = MODE_ACCESS;
      else if (pick < 78) mode = MODE_UNPIN;
      else                mode = MODE_WRITE;
      pin = (mode == MODE_ALLOC) ? ($urandom_range(3) == 0) : 1'($urandom_range(1));
      send_request(mode, 6'($urandom_range(63)), pin, 1'($urandom_range(1)));
    end
  endtask

  initial begin : stimulus
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    run_random();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("checked %0d results: %0d allocations, %0d write-backs, %0d with no victim",
             sb.checked, sb.allocations, sb.writebacks, sb.no_victims);
    $display("traffic ran under both stall mixes, a %0d-cycle output hold and a fully pinned pool",
             LONG_HOLD);
    if (sb.mismatches == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
